>>> src/mfd_pkg.sv
`default_nettype none
package mfd_pkg;

  // Frame positions
  localparam logic [3:0] POS_IDLE = 4'd15;
  localparam logic [3:0] POS_LAST = 4'd13;
  localparam logic [3:0] POS_SIGN = 4'd0;
  localparam logic [3:0] POS_DIG1 = 4'd1;
  localparam logic [3:0] POS_DIG2 = 4'd2;
  localparam logic [3:0] POS_DIG3 = 4'd3;
  localparam logic [3:0] POS_DIG4 = 4'd4;
  localparam logic [3:0] POS_POINT = 4'd6;
  localparam logic [3:0] POS_MODE = 4'd7;
  localparam logic [3:0] POS_EXTRA = 4'd8;
  localparam logic [3:0] POS_RANGE = 4'd9;
  localparam logic [3:0] POS_UNIT = 4'd10;
  localparam logic [3:0] POS_CR = 4'd12;
  localparam logic [3:0] POS_LF = 4'd13;

  // Byte codes
  localparam logic [7:0] CHR_PLUS = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO = 8'h30;
  localparam logic [7:0] CHR_NINE = 8'h39;
  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_LF = 8'h0A;
  localparam logic [7:0] PT_THREE = 8'h31;
  localparam logic [7:0] PT_TWO = 8'h32;
  localparam logic [7:0] PT_ONE = 8'h34;
  localparam logic [7:0] MODE_DC = 8'h10;
  localparam logic [7:0] MODE_BAD = 8'h0E;
  localparam logic [7:0] EXTRA_MINMAX = 8'h30;
  localparam logic [7:0] RNG_NONE = 8'h00;
  localparam logic [7:0] RNG_40 = 8'h40;
  localparam logic [7:0] RNG_80 = 8'h80;

  // Unit codes
  localparam logic [2:0] UNIT_UA = 3'd0;
  localparam logic [2:0] UNIT_MA = 3'd1;
  localparam logic [2:0] UNIT_A = 3'd2;
  localparam logic [2:0] UNIT_MV = 3'd3;
  localparam logic [2:0] UNIT_V = 3'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIGN = 3'd1,
    ST_BAD_DIG  = 3'd2,
    ST_BAD_TERM = 3'd3,
    ST_BAD_MODE = 3'd4,
    ST_BAD_UNIT = 3'd5
  } status_t;

  typedef struct packed {
    logic        publish;
    logic [2:0]  unit;
    logic [1:0]  decimals;
    logic [14:0] reading;
    status_t     status;
  } result_t;

endpackage
`default_nettype wire

>>> src/mfd_decode.sv
`default_nettype none
module mfd_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  input  wire logic [7:0]      data_byte,
  input  wire logic            frame_start,
  input  wire logic [2:0]      desired_unit,
  output mfd_pkg::result_t     result,
  output logic                 result_valid
);

  logic [3:0]       pos;
  logic [3:0]       pos_next;
  logic             neg;
  logic             neg_next;
  logic [13:0]      total;
  logic [13:0]      total_next;
  logic [1:0]       places;
  logic [1:0]       places_next;
  logic [7:0]       mode;
  logic [7:0]       mode_next;
  logic [7:0]       range_byte;
  logic [7:0]       range_byte_next;
  mfd_pkg::status_t fault;
  mfd_pkg::status_t fault_next;

  // Frame position (control state)
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= mfd_pkg::POS_IDLE;
    end else if (item_valid) begin
      pos <= pos_next;
    end
  end

  // Frame fields
  always_ff @(posedge clk) begin
    if (item_valid) begin
      neg        <= neg_next;
      total      <= total_next;
      places     <= places_next;
      mode       <= mode_next;
      range_byte <= range_byte_next;
      fault      <= fault_next;
    end
  end

  // Byte decode; a start flag restarts from a cleared frame
  always_comb begin
    logic [3:0]       p;
    logic [13:0]      digit;
    logic             is_digit;
    mfd_pkg::status_t code;
    logic             hit;
    logic [2:0]       u;
    logic [14:0]      mag;

    p               = frame_start ? mfd_pkg::POS_SIGN : pos;
    neg_next        = frame_start ? 1'b0 : neg;
    total_next      = frame_start ? 14'd0 : total;
    places_next     = frame_start ? 2'd0 : places;
    mode_next       = frame_start ? 8'd0 : mode;
    range_byte_next = frame_start ? 8'd0 : range_byte;
    fault_next      = frame_start ? mfd_pkg::ST_OK : fault;
    code            = mfd_pkg::ST_OK;
    hit             = 1'b0;
    u               = 3'd0;
    is_digit        = (data_byte >= mfd_pkg::CHR_ZERO) && (data_byte <= mfd_pkg::CHR_NINE);
    digit           = is_digit ? {10'd0, data_byte[3:0]} : 14'd0;
    mag             = 15'd0;

    case (p)
      mfd_pkg::POS_SIGN: begin
        if (data_byte == mfd_pkg::CHR_PLUS) begin
          neg_next = 1'b0;
        end else if (data_byte == mfd_pkg::CHR_MINUS) begin
          neg_next = 1'b1;
        end else begin
          code = mfd_pkg::ST_BAD_SIGN;
        end
      end
      mfd_pkg::POS_DIG1, mfd_pkg::POS_DIG2, mfd_pkg::POS_DIG3, mfd_pkg::POS_DIG4: begin
        // times ten as shift and add, kept to 14 bits
        total_next = (total_next << 3) + (total_next << 1) + digit;
        if (!is_digit) begin
          code = mfd_pkg::ST_BAD_DIG;
        end
      end
      mfd_pkg::POS_POINT: begin
        if (data_byte == mfd_pkg::PT_THREE) begin
          places_next = 2'd3;
        end else if (data_byte == mfd_pkg::PT_TWO) begin
          places_next = 2'd2;
        end else if (data_byte == mfd_pkg::PT_ONE) begin
          places_next = 2'd1;
        end else begin
          places_next = 2'd0;
        end
      end
      mfd_pkg::POS_MODE: begin
        mode_next = data_byte;
      end
      mfd_pkg::POS_EXTRA: begin
        if ((mode_next & mfd_pkg::MODE_DC) == 8'd0 || (mode_next & mfd_pkg::MODE_BAD) != 8'd0
            || (data_byte & mfd_pkg::EXTRA_MINMAX) != 8'd0) begin
          code = mfd_pkg::ST_BAD_MODE;
        end
      end
      mfd_pkg::POS_RANGE: begin
        range_byte_next = data_byte;
      end
      mfd_pkg::POS_UNIT: begin
        if (data_byte == mfd_pkg::RNG_40) begin
          if (range_byte_next == mfd_pkg::RNG_80) begin
            u = mfd_pkg::UNIT_UA; hit = 1'b1;
          end else if (range_byte_next == mfd_pkg::RNG_40) begin
            u = mfd_pkg::UNIT_MA; hit = 1'b1;
          end else if (range_byte_next == mfd_pkg::RNG_NONE) begin
            u = mfd_pkg::UNIT_A; hit = 1'b1;
          end
        end else if (data_byte == mfd_pkg::RNG_80) begin
          if (range_byte_next == mfd_pkg::RNG_40) begin
            u = mfd_pkg::UNIT_MV; hit = 1'b1;
          end else if (range_byte_next == mfd_pkg::RNG_NONE) begin
            u = mfd_pkg::UNIT_V; hit = 1'b1;
          end
        end
        range_byte_next = {5'd0, u};
        if (!hit) begin
          code = mfd_pkg::ST_BAD_UNIT;
        end
      end
      mfd_pkg::POS_CR: begin
        if (data_byte != mfd_pkg::CHR_CR) begin
          code = mfd_pkg::ST_BAD_TERM;
        end
      end
      mfd_pkg::POS_LF: begin
        if (data_byte != mfd_pkg::CHR_LF) begin
          code = mfd_pkg::ST_BAD_TERM;
        end
      end
      default: begin
      end
    endcase

    // lowest fault code wins
    if (code != mfd_pkg::ST_OK && (fault_next == mfd_pkg::ST_OK || code < fault_next)) begin
      fault_next = code;
    end

    // position advance; idle positions ignore the byte
    if (p > mfd_pkg::POS_LAST) begin
      pos_next = p;
    end else if (p == mfd_pkg::POS_LAST) begin
      pos_next = mfd_pkg::POS_IDLE;
    end else begin
      pos_next = p + 4'd1;
    end

    // result assembly on the last byte
    result_valid = item_valid && (p == mfd_pkg::POS_LAST);
    mag          = {1'b0, total_next};
    result       = '0;
    result.status = fault_next;
    if (fault_next == mfd_pkg::ST_OK) begin
      result.reading  = neg_next ? (15'd0 - mag) : mag;
      result.decimals = places_next;
      result.unit     = range_byte_next[2:0];
      result.publish  = (range_byte_next[2:0] == desired_unit);
    end
  end

  // The last byte always leaves the decoder idle
  assert property (@(posedge clk) disable iff (rst)
    result_valid |=> (pos == mfd_pkg::POS_IDLE))
    else $error("decoder not idle after frame result");

  // A frame never parks at position fourteen
  assert property (@(posedge clk) disable iff (rst) pos != 4'd14)
    else $error("decoder position fourteen reached");

endmodule
`default_nettype wire

>>> src/mfd_skid.sv
`default_nettype none
module mfd_skid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire mfd_pkg::result_t  in_data,
  output logic                   in_ready,
  output logic                   out_valid,
  output mfd_pkg::result_t       out_data,
  input  wire logic              out_ready
);

  logic             skid_valid;
  mfd_pkg::result_t skid_data;

  assign in_ready = !skid_valid;

  // Output register with one spare slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid) begin
      skid_data <= in_data;
    end
  end

  // Spare slot only fills behind a stalled output
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("spare slot holds an item ahead of the output");

  // No item arrives while the spare slot is full
  assert property (@(posedge clk) disable iff (rst) !(in_valid && skid_valid))
    else $error("item pushed into a full buffer");

endmodule
`default_nettype wire

>>> src/meter_frame_decoder_top.sv
// Meter reading frame decoder, one byte item per cycle while s_tready is high.
// Throughput: one input item every cycle while s_tready is high; a result leaves after the 14th byte.
// A result is registered onto m_tvalid once its last byte is accepted, or held in the spare slot while m_tready is low.
// A two-slot output buffer keeps input flowing while a result waits.
// Reset (rst, synchronous): decoder idle until a start flag, desired_unit 0,
// output empty.
`default_nettype none
module meter_frame_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  s_tuser,   // [0] frame_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [2:0] status, [17:3] reading, [19:18] decimals,
                                      // [22:20] unit, [23] zero
  output logic [0:0]       m_tuser,   // [0] publish
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data   // desired_unit
);

  logic             desired_unit;
  logic [2:0]       desired_reg;
  logic             accept;
  logic             res_valid;
  mfd_pkg::result_t res;
  mfd_pkg::result_t out_res;

  assign cfg_ready    = 1'b1;
  assign desired_unit = cfg_valid && cfg_ready;
  assign accept       = s_tvalid && s_tready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      desired_reg <= mfd_pkg::UNIT_UA;
    end else if (desired_unit) begin
      desired_reg <= cfg_data;
    end
  end

  mfd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (accept),
    .data_byte    (s_tdata),
    .frame_start  (s_tuser[0]),
    .desired_unit (desired_reg),
    .result       (res),
    .result_valid (res_valid)
  );

  mfd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_data  (out_res),
    .out_ready (m_tready)
  );

  // Output packing
  assign m_tdata = {1'b0, out_res.unit, out_res.decimals, out_res.reading, out_res.status};
  assign m_tuser = out_res.publish;

endmodule
`default_nettype wire
